### sv/slie_pkg.sv
package slie_pkg;

    localparam int DEPTH      = 16;
    localparam int WORD_BITS  = 32;

    localparam int CMD_BITS   = 2;
    localparam int POS_BITS   = 8;
    localparam int DATA_BITS  = 32;
    localparam int CNT_OUT_BITS = 5;
    localparam int STATUS_BITS  = 2;

    localparam int COUNT_BITS = $clog2(DEPTH + 1);
    localparam int IDX_BITS   = $clog2(DEPTH);
    localparam int CMP_BITS   = (COUNT_BITS > POS_BITS) ? COUNT_BITS : POS_BITS;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_APPEND = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_ERASE  = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // Per-cell move controls, at most one set in any cycle.
    typedef struct packed {
        logic load;
        logic from_left;
        logic from_right;
    } cell_ctl_t;

endpackage

### sv/slie_cell.sv
module slie_cell (
    input  logic               aclk,
    input  slie_pkg::cell_ctl_t ctl,
    input  slie_pkg::word_t    load_word,
    input  slie_pkg::word_t    left_word,
    input  slie_pkg::word_t    right_word,
    output slie_pkg::word_t    word
);
    import slie_pkg::*;

    word_t word_reg;
    word_t word_next;

    always_comb begin
        word_next = word_reg;
        if (ctl.load) begin
            word_next = load_word;
        end else if (ctl.from_left) begin
            word_next = left_word;
        end else if (ctl.from_right) begin
            word_next = right_word;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word = word_reg;

    a_ctl_exclusive: assert property (@(posedge aclk)
        $onehot0({ctl.load, ctl.from_left, ctl.from_right}))
        else $error("cell given more than one move in a cycle");

endmodule

### sv/shift_list_insert_erase.sv
// Latency: a result appears in the cycle after its command transfer.
// Throughput: one command per cycle while results are taken at once; each
// cell from the position up shifts or loads in the same cycle. A result held
// back by m_ready keeps s_ready low until that result is transferred.
// Reset (synchronous, active low) empties the list and drops any pending
// result; entry contents are not cleared.
module shift_list_insert_erase (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [slie_pkg::CMD_BITS-1:0]      s_cmd,
    input  logic [slie_pkg::POS_BITS-1:0]      s_position,
    input  logic signed [slie_pkg::DATA_BITS-1:0] s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [slie_pkg::DATA_BITS-1:0] m_read_data,
    output logic [slie_pkg::CNT_OUT_BITS-1:0]  m_count_now,
    output logic [slie_pkg::STATUS_BITS-1:0]   m_status
);
    import slie_pkg::*;

    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  m_valid_reg, m_valid_next;
    logic signed [DATA_BITS-1:0] m_read_data_reg, m_read_data_next;
    logic [CNT_OUT_BITS-1:0] m_count_now_reg;
    status_t               m_status_reg, m_status_next;

    logic                  accept;
    cmd_t                  cmd;
    logic [CMP_BITS-1:0]   count_cmp;
    logic [CMP_BITS-1:0]   pos_cmp;
    logic [CMP_BITS-1:0]   ins_pos;
    logic                  is_ins;
    logic                  do_insert;
    logic                  do_erase;
    word_t                 load_word;
    word_t                 words [DEPTH];
    word_t                 read_word;

    assign accept    = s_valid && s_ready;
    assign s_ready   = !m_valid_reg || m_ready;
    assign cmd       = cmd_t'(s_cmd);
    assign count_cmp = CMP_BITS'(count_reg);
    assign pos_cmp   = CMP_BITS'(s_position);
    assign is_ins    = (cmd == CMD_APPEND) || (cmd == CMD_INSERT);
    assign ins_pos   = (cmd == CMD_APPEND) ? count_cmp : pos_cmp;
    assign load_word = WORD_BITS'($unsigned(s_value));
    assign read_word = words[IDX_BITS'(pos_cmp)];

    always_comb begin
        m_status_next = STATUS_OK;
        case (cmd)
            CMD_APPEND, CMD_INSERT: begin
                if (ins_pos > count_cmp) begin
                    m_status_next = STATUS_RANGE;
                end else if (count_reg == COUNT_BITS'(DEPTH)) begin
                    m_status_next = STATUS_FULL;
                end
            end
            CMD_ERASE, CMD_READ: begin
                if (pos_cmp >= count_cmp) begin
                    m_status_next = STATUS_RANGE;
                end
            end
            default: begin
                m_status_next = STATUS_RANGE;
            end
        endcase
    end

    assign do_insert = accept && is_ins && (m_status_next == STATUS_OK);
    assign do_erase  = accept && (cmd == CMD_ERASE) && (m_status_next == STATUS_OK);

    always_comb begin
        count_next = count_reg;
        if (do_insert) begin
            count_next = count_reg + COUNT_BITS'(1);
        end else if (do_erase) begin
            count_next = count_reg - COUNT_BITS'(1);
        end
    end

    // Stored words fill the field as signed values; entry and field widths are equal.
    always_comb begin
        m_read_data_next = '0;
        if ((cmd == CMD_READ) && (m_status_next == STATUS_OK)) begin
            m_read_data_next = DATA_BITS'($signed(read_word));
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        cell_ctl_t ctl;
        word_t     left_word;
        word_t     right_word;

        assign ctl.load       = do_insert && (CMP_BITS'(i) == ins_pos);
        assign ctl.from_left  = do_insert && (CMP_BITS'(i) > ins_pos);
        assign ctl.from_right = do_erase && (CMP_BITS'(i) >= pos_cmp);

        // The chain ends take the incoming word; those moves only touch
        // entries at or beyond the new count.
        if (i == 0) begin : g_first
            assign left_word = load_word;
        end else begin : g_left
            assign left_word = words[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_word = load_word;
        end else begin : g_right
            assign right_word = words[i+1];
        end

        slie_cell u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .load_word  (load_word),
            .left_word  (left_word),
            .right_word (right_word),
            .word       (words[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_read_data_reg <= m_read_data_next;
            m_count_now_reg <= CNT_OUT_BITS'(count_next);
            m_status_reg    <= m_status_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;
    assign m_count_now = m_count_now_reg;
    assign m_status    = m_status_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_BITS'(DEPTH))
        else $error("entry count beyond list depth");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_status_reg == STATUS_FULL)
        |-> m_count_now_reg == CNT_OUT_BITS'(DEPTH))
        else $error("full status reported below depth");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        do_insert |=> count_reg == $past(count_reg) + COUNT_BITS'(1))
        else $error("good insert did not grow the list");

    a_idle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(count_reg))
        else $error("count moved without a command transfer");

endmodule
